>>> rtl/core/dcrc_pkg.sv
// ----------------------------------------------------------------------------
// dcrc_pkg: shared types and constants of the daisy-chain reply checker
// Holds the status codes, register indexes, item and result layouts and the
// CRC-8 byte step (polynomial 0x07, initial value zero).
// ----------------------------------------------------------------------------
package dcrc_pkg;

  // reply buffer depth default; the five-bit stored index covers depths up to 32
  localparam int unsigned ReplyBufferDepthDef = 32;

  // number of configuration registers and their address bits
  localparam int unsigned NumRegs   = 4;
  localparam int unsigned RegIdxW   = 2;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;

  // frame constants
  localparam logic [7:0] BlockingBit    = 8'h80;
  localparam logic [7:0] FirstByteMask  = 8'h7f;
  localparam logic [7:0] NoReplyWrHead  = 8'h01;
  localparam logic [7:0] NoReplyRdHead  = 8'h00;
  localparam int unsigned WriteReplyLen = 4;
  localparam int unsigned EchoLen       = 3;
  localparam int unsigned ReadExtraLen  = 4;
  localparam logic [7:0] CrcPoly        = 8'h07;

  // result status codes
  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_BUSY    = 3'd1,
    ST_OK      = 3'd2,
    ST_NOREPLY = 3'd3,
    ST_ECHO    = 3'd4,
    ST_CRC     = 3'd5,
    ST_OVF     = 3'd6,
    ST_FERR    = 3'd7
  } status_e;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_HEAD     = 2'd0,
    REG_REGISTER = 2'd1,
    REG_COUNT    = 2'd2,
    REG_WR_CRC   = 2'd3
  } reg_idx_e;

  // one input item
  typedef struct packed {
    logic       mode;
    logic [7:0] received_byte;
    logic       framing_error;
    logic       receiver_overrun;
  } item_t;

  // one result item
  typedef struct packed {
    status_e    reply_status;
    logic       reply_done;
    logic [7:0] stored_byte;
    logic [4:0] stored_index;
    logic       stored_valid;
  } result_t;

  // request bytes as seen by the checker
  typedef logic [NumRegs-1:0][7:0] req_t;

  // one byte of CRC-8, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/dcrc_cfg.sv
// ----------------------------------------------------------------------------
// dcrc_cfg: request register file
// Holds the four request bytes behind an APB-style port; writes land in the
// access phase, reads return the addressed byte.
// ----------------------------------------------------------------------------
module dcrc_cfg
  import dcrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output req_t              req_o
);

  req_t             req_q;
  logic             wr_en;
  logic [RegIdxW-1:0] idx;

  assign idx    = paddr[RegIdxW+1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign req_o  = req_q;

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else if (wr_en) begin
      req_q[idx] <= pwdata[7:0];
    end
  end

  // read decode
  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(idx))
      REG_HEAD:     prdata[7:0] = req_q[REG_HEAD];
      REG_REGISTER: prdata[7:0] = req_q[REG_REGISTER];
      REG_COUNT:    prdata[7:0] = req_q[REG_COUNT];
      REG_WR_CRC:   prdata[7:0] = req_q[REG_WR_CRC];
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/dcrc_step.sv
// ----------------------------------------------------------------------------
// dcrc_step: per-item reply check
// Combinational evaluation of one item against the reply state: error flags, echo,
// length, blocking bit and CRC checks, giving the result and the next state.
// ----------------------------------------------------------------------------
module dcrc_step
  import dcrc_pkg::*;
#(
  parameter int unsigned ReplyBufferDepth = ReplyBufferDepthDef,
  parameter int unsigned CntW             = $clog2(ReplyBufferDepth + 1)
) (
  input  item_t           item_i,
  input  req_t            req_i,
  input  logic [CntW-1:0] count_i,
  input  logic [7:0]      crc_i,
  input  logic            blocking_i,
  input  logic            active_i,
  output logic [CntW-1:0] count_o,
  output logic [7:0]      crc_o,
  output logic            blocking_o,
  output logic            active_o,
  output result_t         res_o
);

  logic [7:0]      data;
  logic [7:0]      crc_cur;
  logic            blk_cur;
  logic [CntW-1:0] cnt_inc;
  logic [8:0]      read_len;

  assign cnt_inc  = count_i + CntW'(1);
  assign read_len = 9'(req_i[REG_COUNT]) + 9'(ReadExtraLen);

  always_comb begin
    count_o    = count_i;
    crc_o      = crc_i;
    blocking_o = blocking_i;
    active_o   = active_i;
    res_o      = '0;
    data       = item_i.received_byte;
    crc_cur    = crc_i;
    blk_cur    = blocking_i;

    if (!item_i.mode) begin
      // start transfer opens a fresh reply
      active_o          = 1'b1;
      count_o           = '0;
      crc_o             = '0;
      blocking_o        = 1'b0;
      res_o.reply_status = ST_BUSY;
    end else if (active_i) begin
      res_o.reply_status = ST_BUSY;
      if (item_i.framing_error) begin
        res_o.reply_status = ST_FERR;
        res_o.reply_done   = 1'b1;
      end else if (item_i.receiver_overrun) begin
        res_o.reply_status = ST_OVF;
        res_o.reply_done   = 1'b1;
      end else begin
        // first byte carries the blocking bit
        if (count_i == '0) begin
          crc_cur    = '0;
          blk_cur    = |(data & BlockingBit);
          data       = data & FirstByteMask;
          crc_o      = '0;
          blocking_o = blk_cur;
        end
        if (count_i >= CntW'(ReplyBufferDepth)) begin
          res_o.reply_status = ST_OVF;
          res_o.reply_done   = 1'b1;
        end else if (count_i < CntW'(EchoLen) && req_i[count_i[RegIdxW-1:0]] != data) begin
          res_o.reply_status = ST_ECHO;
          res_o.reply_done   = 1'b1;
        end else begin
          res_o.stored_byte  = data;
          res_o.stored_index = 5'(count_i);
          res_o.stored_valid = 1'b1;
          count_o            = cnt_inc;
          if (req_i[REG_HEAD][0]) begin
            // write reply: four bytes, last one echoes the request crc
            if (cnt_inc == CntW'(WriteReplyLen)) begin
              res_o.reply_done = 1'b1;
              if (req_i[REG_WR_CRC] != data) begin
                res_o.reply_status = ST_ECHO;
              end else if (req_i[REG_HEAD] == NoReplyWrHead && !blk_cur) begin
                res_o.reply_status = ST_NOREPLY;
              end else begin
                res_o.reply_status = ST_OK;
              end
            end
          end else begin
            // read reply: data bytes then crc
            if (cnt_inc == CntW'(EchoLen) && req_i[REG_HEAD] == NoReplyRdHead && !blk_cur) begin
              res_o.reply_status = ST_NOREPLY;
              res_o.reply_done   = 1'b1;
            end else if (9'(cnt_inc) == read_len) begin
              res_o.reply_status = (crc_cur != data) ? ST_CRC : ST_OK;
              res_o.reply_done   = 1'b1;
            end else begin
              crc_o = crc8_step(crc_cur, data);
            end
          end
        end
      end
      if (res_o.reply_done) begin
        active_o = 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/daisy_chain_reply_checker.sv
// ----------------------------------------------------------------------------
// daisy_chain_reply_checker: reply byte checker for a daisy-chained bus
// Stages: input register, check logic, result register.
// Throughput one item per cycle while results are taken; a waiting result
// stalls the input once the input register holds an item.
// Asynchronous active-low reset clears the reply state and the request bytes.
// ----------------------------------------------------------------------------
module daisy_chain_reply_checker
  import dcrc_pkg::*;
#(
  parameter int unsigned ReplyBufferDepth = ReplyBufferDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [7:0]        received_byte_i,
  input  logic              framing_error_i,
  input  logic              receiver_overrun_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        reply_status_o,
  output logic              reply_done_o,
  output logic [7:0]        stored_byte_o,
  output logic [4:0]        stored_index_o,
  output logic              stored_valid_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CntW = $clog2(ReplyBufferDepth + 1);

  req_t            req;
  logic            in_valid_q;
  item_t           in_item_q;
  logic            out_valid_q;
  result_t         out_res_q;
  logic            adv;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      crc_q, crc_d;
  logic            blocking_q, blocking_d;
  logic            active_q, active_d;
  result_t         res;

  // request registers
  dcrc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_o   (req)
  );

  // handshake: item moves on when the result register is free or drained
  assign adv        = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= '{mode:             mode_i,
                     received_byte:    received_byte_i,
                     framing_error:    framing_error_i,
                     receiver_overrun: receiver_overrun_i};
    end
  end

  // check logic
  dcrc_step #(
    .ReplyBufferDepth (ReplyBufferDepth),
    .CntW             (CntW)
  ) u_step (
    .item_i     (in_item_q),
    .req_i      (req),
    .count_i    (count_q),
    .crc_i      (crc_q),
    .blocking_i (blocking_q),
    .active_i   (active_q),
    .count_o    (count_d),
    .crc_o      (crc_d),
    .blocking_o (blocking_d),
    .active_o   (active_d),
    .res_o      (res)
  );

  // reply state, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      crc_q      <= '0;
      blocking_q <= 1'b0;
      active_q   <= 1'b0;
    end else if (adv) begin
      count_q    <= count_d;
      crc_q      <= crc_d;
      blocking_q <= blocking_d;
      active_q   <= active_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reply_status_o = out_res_q.reply_status;
  assign reply_done_o   = out_res_q.reply_done;
  assign stored_byte_o  = out_res_q.stored_byte;
  assign stored_index_o = out_res_q.stored_index;
  assign stored_valid_o = out_res_q.stored_valid;

`ifndef SYNTHESIS
  // byte count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ReplyBufferDepth))
    else $error("byte count beyond buffer depth");

  // a finished reply leaves no reply open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.reply_done |=> !active_q)
    else $error("reply still open after done");

  // a stored byte never comes with an ignore, overflow or framing status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stored_valid_o |->
      reply_status_o != ST_IGNORED && reply_status_o != ST_OVF && reply_status_o != ST_FERR)
    else $error("stored byte with non-storing status");

  // done only with a final status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_done_o |->
      reply_status_o != ST_IGNORED && reply_status_o != ST_BUSY)
    else $error("reply done with open status");

  // an ignored byte leaves the reply state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.reply_status == ST_IGNORED |=> $stable(count_q) && !active_q)
    else $error("ignored byte changed reply state");
`endif

endmodule

>>> sim/tb_daisy_chain_reply_checker.sv
// ----------------------------------------------------------------------------
// tb_daisy_chain_reply_checker: self-checking bench for the reply checker
// A short table of directed frames runs first, then random reply frames are
// sent under several request settings. Every result transfer is compared
// field by field with the oldest prediction, under random idling on both
// sides until the calm last fifth of the random items.
// ----------------------------------------------------------------------------
module tb_daisy_chain_reply_checker;
  import dcrc_pkg::*;

  localparam int unsigned RandomItems = 1900;

  typedef enum logic {
    ROW_SETUP,
    ROW_ITEM
  } row_kind_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e kind;
    item_t     it;
    logic      has_exp;
    result_t   exp;
    req_t      setup;
  } row_t;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              in_valid_i         = 1'b0;
  logic              in_ready_o;
  logic              mode_i             = 1'b0;
  logic [7:0]        received_byte_i    = 8'h00;
  logic              framing_error_i    = 1'b0;
  logic              receiver_overrun_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i        = 1'b0;
  logic [2:0]        reply_status_o;
  logic              reply_done_o;
  logic [7:0]        stored_byte_o;
  logic [4:0]        stored_index_o;
  logic              stored_valid_o;
  logic              psel               = 1'b0;
  logic              penable            = 1'b0;
  logic              pwrite             = 1'b0;
  logic [PaddrW-1:0] paddr              = '0;
  logic [PdataW-1:0] pwdata             = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  // typed-in expectation travelling with the item
  logic              typed_given        = 1'b0;
  result_t           typed_reply        = '0;

  // checker copy of the request bytes and the reply state
  req_t              req_bytes          = '0;
  int unsigned       chk_count          = 0;
  logic [7:0]        chk_crc            = 8'h00;
  logic              chk_blocking       = 1'b0;
  logic              chk_open           = 1'b0;

  result_t           expected_replies [$];
  int unsigned       fail_count         = 0;
  int unsigned       items_sent         = 0;
  bit                calm               = 1'b0;

  daisy_chain_reply_checker i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .received_byte_i    (received_byte_i),
    .framing_error_i    (framing_error_i),
    .receiver_overrun_i (receiver_overrun_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .reply_status_o     (reply_status_o),
    .reply_done_o       (reply_done_o),
    .stored_byte_o      (stored_byte_o),
    .stored_index_o     (stored_index_o),
    .stored_valid_o     (stored_valid_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // crc-8, polynomial 0x07, one data bit at a time, msb first
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return acc;
  endfunction

  // expected result of one accepted item, advances the checker state
  function automatic result_t predict_reply(item_t it);
    result_t    r;
    logic [7:0] b;
    r = '0;
    r.reply_status = ST_IGNORED;
    b = it.received_byte;
    if (!it.mode) begin
      chk_open       = 1'b1;
      chk_count      = 0;
      chk_crc        = 8'h00;
      chk_blocking   = 1'b0;
      r.reply_status = ST_BUSY;
    end else if (chk_open) begin
      r.reply_status = ST_BUSY;
      if (it.framing_error) begin
        r.reply_status = ST_FERR;
        r.reply_done   = 1'b1;
      end else if (it.receiver_overrun) begin
        r.reply_status = ST_OVF;
        r.reply_done   = 1'b1;
      end else begin
        // first byte carries the blocking bit
        if (chk_count == 0) begin
          chk_crc      = 8'h00;
          chk_blocking = (b & BlockingBit) != 8'h00;
          b            = b & FirstByteMask;
        end
        if (chk_count >= ReplyBufferDepthDef) begin
          r.reply_status = ST_OVF;
          r.reply_done   = 1'b1;
        end else if (chk_count < EchoLen && req_bytes[chk_count] != b) begin
          r.reply_status = ST_ECHO;
          r.reply_done   = 1'b1;
        end else begin
          r.stored_byte  = b;
          r.stored_index = 5'(chk_count);
          r.stored_valid = 1'b1;
          chk_count++;
          if (req_bytes[REG_HEAD][0]) begin
            // write reply ends on the crc echo
            if (chk_count == WriteReplyLen) begin
              if (req_bytes[REG_WR_CRC] != b) begin
                r.reply_status = ST_ECHO;
              end else if (req_bytes[REG_HEAD] == NoReplyWrHead && !chk_blocking) begin
                r.reply_status = ST_NOREPLY;
              end else begin
                r.reply_status = ST_OK;
              end
              r.reply_done = 1'b1;
            end
          end else begin
            if (chk_count == EchoLen && req_bytes[REG_HEAD] == NoReplyRdHead &&
                !chk_blocking) begin
              r.reply_status = ST_NOREPLY;
              r.reply_done   = 1'b1;
            end else if (chk_count == req_bytes[REG_COUNT] + ReadExtraLen) begin
              r.reply_status = (chk_crc != b) ? ST_CRC : ST_OK;
              r.reply_done   = 1'b1;
            end else begin
              chk_crc = crc8_next(chk_crc, b);
            end
          end
        end
      end
      if (r.reply_done) begin
        chk_open = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (fail_count < 40) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
      fail_count++;
    end
  endtask

  // result check and prediction on every transfer
  always @(posedge clk_i) begin : reply_scoreboard
    result_t want;
    item_t   taken;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          if (fail_count < 40) begin
            $error("result transfer with no expectation waiting");
          end
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("reply_status", 8'(want.reply_status), 8'(reply_status_o));
          check_field("reply_done", 8'(want.reply_done), 8'(reply_done_o));
          check_field("stored_byte", want.stored_byte, stored_byte_o);
          check_field("stored_index", 8'(want.stored_index), 8'(stored_index_o));
          check_field("stored_valid", 8'(want.stored_valid), 8'(stored_valid_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        taken.mode             = mode_i;
        taken.received_byte    = received_byte_i;
        taken.framing_error    = framing_error_i;
        taken.receiver_overrun = receiver_overrun_i;
        want = predict_reply(taken);
        if (typed_given) begin
          want = typed_reply;
        end
        expected_replies.push_back(want);
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
        if ($urandom_range(0, 2) != 0) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
    end
  end

  // one item transfer, with an optional idle burst in front
  task automatic send_item(item_t it, logic has_exp, result_t exp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    mode_i             <= it.mode;
    received_byte_i    <= it.received_byte;
    framing_error_i    <= it.framing_error;
    receiver_overrun_i <= it.receiver_overrun;
    typed_given        <= has_exp;
    typed_reply        <= exp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    req_bytes[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // new request bytes, only with the checker idle
  task automatic load_request(req_t r);
    wait_drained();
    for (int i = 0; i < NumRegs; i++) begin
      apb_write(reg_idx_e'(i), r[i]);
    end
  endtask

  function automatic row_t row_item(bit m, logic [7:0] b, bit fe, bit ov);
    row_t row;
    row = '0;
    row.kind                = ROW_ITEM;
    row.it.mode             = m;
    row.it.received_byte    = b;
    row.it.framing_error    = fe;
    row.it.receiver_overrun = ov;
    return row;
  endfunction

  function automatic row_t row_item_exp(bit m, logic [7:0] b, bit fe, bit ov, status_e st,
                                        bit done, logic [7:0] sb, logic [4:0] si, bit sv);
    row_t row;
    row = row_item(m, b, fe, ov);
    row.has_exp          = 1'b1;
    row.exp.reply_status = st;
    row.exp.reply_done   = done;
    row.exp.stored_byte  = sb;
    row.exp.stored_index = si;
    row.exp.stored_valid = sv;
    return row;
  endfunction

  function automatic row_t row_setup(logic [7:0] head, logic [7:0] regad, logic [7:0] cnt,
                                     logic [7:0] wcrc);
    row_t row;
    row = '0;
    row.kind               = ROW_SETUP;
    row.setup[REG_HEAD]     = head;
    row.setup[REG_REGISTER] = regad;
    row.setup[REG_COUNT]    = cnt;
    row.setup[REG_WR_CRC]   = wcrc;
    return row;
  endfunction

  // one reply frame for the current request, sometimes damaged or cut short
  task automatic send_reply();
    logic [7:0]  frame [$];
    logic [7:0]  crc;
    logic [1:0]  flags;
    int unsigned len;
    int unsigned cut;
    int unsigned err_at;
    int unsigned bad_at;
    item_t       it;
    frame.push_back((req_bytes[REG_HEAD] & FirstByteMask) |
                    ($urandom_range(0, 1) ? BlockingBit : 8'h00));
    frame.push_back(req_bytes[REG_REGISTER]);
    frame.push_back(req_bytes[REG_COUNT]);
    if (req_bytes[REG_HEAD][0]) begin
      frame.push_back(req_bytes[REG_WR_CRC]);
    end else begin
      // long reads stop one byte past the buffer
      len = req_bytes[REG_COUNT] + ReadExtraLen;
      if (len > ReplyBufferDepthDef + 1) begin
        len = ReplyBufferDepthDef + 1;
      end
      while (frame.size() < len - 1) frame.push_back(8'($urandom_range(0, 255)));
      crc = 8'h00;
      foreach (frame[i]) begin
        crc = crc8_next(crc, (i == 0) ? (frame[i] & FirstByteMask) : frame[i]);
      end
      frame.push_back(crc);
    end
    if ($urandom_range(0, 7) == 0) begin
      bad_at = $urandom_range(0, frame.size() - 1);
      frame[bad_at] = frame[bad_at] ^ 8'($urandom_range(1, 255));
    end
    err_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, frame.size() - 1) : frame.size();
    cut    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame.size() - 1) : frame.size();

    // start transfer with junk in the unused fields
    it.mode             = 1'b0;
    it.received_byte    = 8'($urandom_range(0, 255));
    it.framing_error    = 1'($urandom_range(0, 1));
    it.receiver_overrun = 1'($urandom_range(0, 1));
    send_item(it, 1'b0, '0);
    items_sent++;
    for (int i = 0; i < cut; i++) begin
      flags               = (i == err_at) ? 2'($urandom_range(1, 3)) : 2'b00;
      it.mode             = 1'b1;
      it.received_byte    = frame[i];
      it.framing_error    = flags[0];
      it.receiver_overrun = flags[1];
      send_item(it, 1'b0, '0);
      items_sent++;
    end

    // stray bytes after the reply, usually ignored
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        it.mode             = 1'b1;
        it.received_byte    = 8'($urandom_range(0, 255));
        it.framing_error    = 1'($urandom_range(0, 1));
        it.receiver_overrun = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
      end
    end
    // fully random noise transfer
    if ($urandom_range(0, 11) == 0) begin
      it.mode             = 1'($urandom_range(0, 1));
      it.received_byte    = 8'($urandom_range(0, 255));
      it.framing_error    = 1'($urandom_range(0, 1));
      it.receiver_overrun = 1'($urandom_range(0, 1));
      send_item(it, 1'b0, '0);
      items_sent++;
    end
  endtask

  // reset, directed table, random phases, final check
  initial begin : stimulus
    row_t        dir_rows [$];
    req_t        next_req;
    int unsigned phase_end;

    // reset request bytes are all zero: a read of address zero
    dir_rows.push_back(row_item_exp(1, 8'hff, 0, 0, ST_IGNORED, 0, 8'h00, 5'd0, 0));
    dir_rows.push_back(row_item_exp(0, 8'h00, 0, 0, ST_BUSY, 0, 8'h00, 5'd0, 0));
    dir_rows.push_back(row_item(1, 8'h80, 0, 0));
    dir_rows.push_back(row_item(1, 8'h00, 0, 0));
    dir_rows.push_back(row_item(1, 8'h00, 0, 0));
    dir_rows.push_back(row_item(1, 8'h00, 0, 0));
    // byte after the reply has ended
    dir_rows.push_back(row_item_exp(1, 8'h00, 0, 0, ST_IGNORED, 0, 8'h00, 5'd0, 0));
    // start ignores the other fields
    dir_rows.push_back(row_item_exp(0, 8'hff, 1, 1, ST_BUSY, 0, 8'h00, 5'd0, 0));
    dir_rows.push_back(row_item(1, 8'h00, 0, 0));
    dir_rows.push_back(row_item(1, 8'h00, 0, 0));
    // read of address zero without the blocking bit
    dir_rows.push_back(row_item_exp(1, 8'h00, 0, 0, ST_NOREPLY, 1, 8'h00, 5'd2, 1));
    // write to address 0x55
    dir_rows.push_back(row_setup(NoReplyWrHead, 8'h55, 8'haa, 8'h3c));
    dir_rows.push_back(row_item(0, 8'h00, 0, 0));
    dir_rows.push_back(row_item(1, 8'h01, 0, 0));
    dir_rows.push_back(row_item(1, 8'h55, 0, 0));
    dir_rows.push_back(row_item(1, 8'haa, 0, 0));
    dir_rows.push_back(row_item(1, 8'h3c, 0, 0));
    // restart mid-reply, then framing wins over overrun
    dir_rows.push_back(row_item(0, 8'h00, 0, 0));
    dir_rows.push_back(row_item(1, 8'h01, 0, 0));
    dir_rows.push_back(row_item(0, 8'h00, 0, 0));
    dir_rows.push_back(row_item_exp(1, 8'h01, 1, 1, ST_FERR, 1, 8'h00, 5'd0, 0));
    dir_rows.push_back(row_item(0, 8'h00, 0, 0));
    dir_rows.push_back(row_item_exp(1, 8'h01, 0, 1, ST_OVF, 1, 8'h00, 5'd0, 0));
    // echo mismatch on the head byte
    dir_rows.push_back(row_item(0, 8'h00, 0, 0));
    dir_rows.push_back(row_item_exp(1, 8'h02, 0, 0, ST_ECHO, 1, 8'h00, 5'd0, 0));
    // write crc echo mismatch, byte still stored
    dir_rows.push_back(row_item(0, 8'h00, 0, 0));
    dir_rows.push_back(row_item(1, 8'h81, 0, 0));
    dir_rows.push_back(row_item(1, 8'h55, 0, 0));
    dir_rows.push_back(row_item(1, 8'haa, 0, 0));
    dir_rows.push_back(row_item_exp(1, 8'h3d, 0, 0, ST_ECHO, 1, 8'h3d, 5'd3, 1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SETUP) begin
        load_request(dir_rows[i].setup);
      end else begin
        send_item(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp);
      end
    end

    // random phases, each under its own request
    while (items_sent < RandomItems) begin
      next_req[REG_HEAD]     = 8'($urandom_range(0, 127)) & 8'hfe;
      next_req[REG_REGISTER] = 8'($urandom_range(0, 255));
      next_req[REG_COUNT]    = 8'($urandom_range(0, 10));
      next_req[REG_WR_CRC]   = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0: next_req = '0;
        1: next_req = '1;
        2: next_req[REG_HEAD] = NoReplyWrHead;
        3: next_req[REG_HEAD] = NoReplyRdHead;
        // read too long for the buffer
        4: next_req[REG_COUNT] = 8'($urandom_range(29, 255));
        5, 6: next_req[REG_HEAD][0] = 1'b1;
        7: begin
          next_req[REG_HEAD]  = 8'($urandom_range(0, 255));
          next_req[REG_COUNT] = 8'($urandom_range(0, 255));
        end
        // longer read, up to one that fills the buffer to the last slot
        8: next_req[REG_COUNT] = 8'($urandom_range(11, 28));
        default: ;
      endcase
      load_request(next_req);
      phase_end = items_sent + $urandom_range(40, 160);
      while (items_sent < phase_end && items_sent < RandomItems) begin
        calm = (items_sent > RandomItems * 4 / 5);
        send_reply();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> daisy_chain_reply_checker.f
rtl/core/dcrc_pkg.sv
rtl/core/dcrc_cfg.sv
rtl/core/dcrc_step.sv
rtl/core/daisy_chain_reply_checker.sv
sim/tb_daisy_chain_reply_checker.sv
